[design/cid_pkg.sv]
// Shared types and constants of the CEL image decoder.
// No dependencies.
package cid_pkg;
  localparam int unsigned PaletteEntries = 256;
  localparam int unsigned PalAw = 8;

  localparam logic [1:0] KindPal   = 2'd0;
  localparam logic [1:0] KindStart = 2'd1;
  localparam logic [1:0] KindData  = 2'd2;

  localparam logic [2:0] CfgBpp    = 3'd0;
  localparam logic [2:0] CfgIndex  = 3'd1;
  localparam logic [2:0] CfgPacked = 3'd2;
  localparam logic [2:0] CfgWidth  = 3'd3;
  localparam logic [2:0] CfgHeight = 3'd4;

  localparam logic [1:0] ModeEnd   = 2'd0;
  localparam logic [1:0] ModeLit   = 2'd1;
  localparam logic [1:0] ModeTrans = 2'd2;
  localparam logic [1:0] ModeRep   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  table_index;
    logic [15:0] table_value;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_color;
    logic [11:0] run_length;
    logic [9:0]  row_number;
    logic        row_done;
    logic        image_done;
    logic        last;
  } out_item_t;

  function automatic logic [4:0] depth_bits(input logic [2:0] code);
    case (code)
      3'd0: depth_bits = 5'd1;
      3'd1: depth_bits = 5'd2;
      3'd2: depth_bits = 5'd4;
      3'd3: depth_bits = 5'd6;
      3'd4: depth_bits = 5'd8;
      default: depth_bits = 5'd16;
    endcase
  endfunction
endpackage

[design/cid_stream_if.sv]
// Valid/ready channel carrying one payload type.
// Depends on cid_pkg.
interface cid_in_if;
  import cid_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cid_out_if;
  import cid_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/cid_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
module cid_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[design/cel_image_decoder_core.sv]
// CEL image decoder: palette writes, image start and data bytes in, pixel runs out.
// A palette write or start is applied when it is accepted. A data byte is accepted in the
// idle state, then decoded step by step (header field, pixel or fill run, row end), a
// palette run passing through the lookup state before its next step.
// Throughput: one item at a time; a step that hands over a run waits while the output
// register is full. Reset: decoder idle, registers at 8bpp indexed packed, 1x1.
module cel_image_decoder_core
  import cid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  cid_in_if.sink      in_i,
  cid_out_if.source   out_o
);
  localparam logic [2:0] PhIdle = 3'd0, PhOffset = 3'd1, PhMode = 3'd2, PhCount = 3'd3,
                         PhPixel = 3'd4, PhRaw = 3'd5, PhSkip = 3'd6, PhDone = 3'd7;
  localparam logic [1:0] SqIdle = 2'd0, SqRun = 2'd1, SqLook = 2'd2;

  logic [2:0]  bpp_q;
  logic        idx_cfg_q, packed_q;
  logic [10:0] wm1_q;
  logic [9:0]  hm1_q;

  logic [1:0]  sq_q, sq_d;
  logic [2:0]  ph_q, ph_d;
  logic [23:0] buf_q, buf_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [9:0]  row_q, row_d;
  logic [11:0] col_q, col_d;
  logic [12:0] rbc_q, rbc_d, rbl_q, rbl_d;
  logic [1:0]  pm_q, pm_d;
  logic [6:0]  prem_q, prem_d;
  logic        ovalid_q, ovalid_d;
  out_item_t   out_q, out_d;
  logic        stage_v_q, stage_v_d;
  out_item_t   stage_q, stage_d;
  logic [1:0]  look_cnt_q, look_cnt_d;

  logic [4:0]       pw;
  logic             indexed;
  logic [11:0]      w;
  logic             ofree;
  logic             pal_we;
  logic [PalAw-1:0] pal_ra;
  logic [15:0]      pal_rd;

  assign pw = depth_bits(bpp_q);
  assign indexed = (pw < 5'd8) ? 1'b1 : ((pw >= 5'd16) ? 1'b0 : idx_cfg_q);
  assign w = {1'b0, wm1_q} + 12'd1;
  assign ofree = !ovalid_q || out_o.ready;

  assign in_i.ready = (sq_q == SqIdle);
  assign out_o.valid = ovalid_q;
  assign out_o.data = out_q;

  assign pal_we = in_i.valid && in_i.ready && (in_i.data.kind == KindPal);

  cid_ram #(.Width(16), .Depth(PaletteEntries)) u_pal (
    .clk_i  (clk_i),
    .we_i   (pal_we),
    .waddr_i(in_i.data.table_index),
    .wdata_i(in_i.data.table_value),
    .raddr_i(pal_ra),
    .rdata_o(pal_rd)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q <= 3'd4; idx_cfg_q <= 1'b1; packed_q <= 1'b1; wm1_q <= '0; hm1_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgBpp:    bpp_q <= cfg_data_i[2:0];
        CfgIndex:  idx_cfg_q <= cfg_data_i[0];
        CfgPacked: packed_q <= cfg_data_i[0];
        CfgWidth:  wm1_q <= cfg_data_i;
        CfgHeight: hm1_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Sequencer: one decode step per cycle, held while a run waits for a full output register
  always_comb begin
    logic [15:0] used;
    logic [12:0] idx;
    logic [4:0]  n;
    logic [15:0] v, mask;
    logic [11:0] left, len, c6;
    logic        do_emit, do_finish, do_begin, lookup, rd, stall;
    logic [15:0] ecol;
    sq_d = sq_q; ph_d = ph_q; buf_d = buf_q; cnt_d = cnt_q; row_d = row_q; col_d = col_q;
    rbc_d = rbc_q; rbl_d = rbl_q; pm_d = pm_q; prem_d = prem_q;
    stage_v_d = stage_v_q; stage_d = stage_q; look_cnt_d = look_cnt_q;
    ovalid_d = ovalid_q && !out_o.ready; out_d = out_q;
    pal_ra = stage_q.pixel_color[PalAw-1:0];
    used = '0; idx = '0; n = '0; v = '0; mask = '0; left = '0; len = '0; c6 = '0;
    do_emit = 1'b0; do_finish = 1'b0; do_begin = 1'b0; lookup = 1'b0; rd = 1'b0;
    stall = 1'b0;
    ecol = '0;

    unique case (sq_q)
      SqIdle: begin
        if (in_i.valid && in_i.ready) begin
          if (in_i.data.kind == KindStart) begin
            row_d = '0; rbl_d = '0; do_begin = 1'b1;
          end else if (in_i.data.kind == KindData) begin
            if (ph_q == PhSkip) begin
              if (rbc_q < 13'd8191) rbc_d = rbc_q + 13'd1;
              if (rbc_d >= rbl_q) do_begin = 1'b1;
            end else if (ph_q != PhIdle && ph_q != PhDone) begin
              buf_d = {buf_q[15:0], in_i.data.data_byte};
              cnt_d = cnt_q + 5'd8;
              if (rbc_q < 13'd8191) rbc_d = rbc_q + 13'd1;
              sq_d = SqRun;
            end
          end
        end
      end
      SqRun: begin
        // width of the field this phase needs
        unique case (ph_q)
          PhOffset: n = (pw >= 5'd8) ? 5'd16 : 5'd8;
          PhMode:   n = 5'd2;
          PhCount:  n = 5'd6;
          default:  n = pw;
        endcase
        mask = (n == 5'd16) ? 16'hFFFF : ((16'd1 << n[3:0]) - 16'd1);
        v = 16'((buf_q >> (cnt_q - n))) & mask;
        used = {rbc_q, 3'b000} - {11'd0, cnt_q};
        idx = used[15:3];
        left = (col_q < w) ? (w - col_q) : 12'd0;
        unique case (ph_q)
          PhOffset: begin
            if (cnt_q < n) sq_d = SqIdle;
            else begin
              cnt_d = cnt_q - n;
              if (n == 5'd16) v = v & 16'h03FF;
              rbl_d = 13'((v[9:0] + 11'd2) * 4);
              ph_d = PhMode;
            end
          end
          PhMode: begin
            if (col_q >= w) do_finish = 1'b1;
            else if (idx >= rbl_q) begin
              do_emit = 1'b1; ecol = '0; len = left; do_finish = 1'b1;
            end else if (cnt_q < 5'd2) sq_d = SqIdle;
            else begin
              cnt_d = cnt_q - 5'd2; pm_d = v[1:0];
              if (v[1:0] == ModeEnd) begin
                do_emit = 1'b1; ecol = '0; len = left; do_finish = 1'b1;
              end else ph_d = PhCount;
            end
          end
          PhCount: begin
            if (cnt_q < 5'd6) sq_d = SqIdle;
            else begin
              cnt_d = cnt_q - 5'd6;
              c6 = {6'd0, v[5:0]} + 12'd1;
              if (c6 > left) c6 = left;
              if (c6 == 12'd0) do_finish = 1'b1;
              else if (pm_q == ModeTrans) begin
                do_emit = 1'b1; ecol = '0; len = c6;
                if (col_q + c6 >= w) do_finish = 1'b1; else ph_d = PhMode;
              end else begin
                prem_d = c6[6:0]; ph_d = PhPixel;
              end
            end
          end
          PhPixel, PhRaw: begin
            if (ph_q == PhRaw && col_q >= w) do_finish = 1'b1;
            else if (cnt_q < pw) sq_d = SqIdle;
            else begin
              cnt_d = cnt_q - pw;
              do_emit = 1'b1;
              len = (ph_q == PhPixel && pm_q == ModeRep) ? {5'd0, prem_q} : 12'd1;
              if (indexed) begin
                lookup = 1'b1; ecol = {8'd0, v[7:0]};
              end else ecol = (ph_q == PhPixel) ? (v | 16'h8000) : v;
              if (ph_q == PhPixel) begin
                prem_d = (pm_q == ModeRep) ? 7'd0 : prem_q - 7'd1;
                if (col_q + len >= w) do_finish = 1'b1;
                else if (prem_d == 7'd0) ph_d = PhMode;
              end else if (col_q + len >= w) do_finish = 1'b1;
            end
          end
          default: sq_d = SqIdle;
        endcase
        // drop the consumed bits from the buffer
        if (cnt_d == 5'd0) buf_d = '0;
        else buf_d = buf_q & ((24'd1 << cnt_d) - 24'd1);
        // stage the new run; a palette run gets its color in the lookup state
        if (do_emit) begin
          rd = (col_q + len) >= w;
          stage_d.pixel_color = ecol;
          stage_d.run_length = len;
          stage_d.row_number = row_q;
          stage_d.row_done = rd;
          stage_d.image_done = rd && (row_q >= hm1_q);
          stage_d.last = 1'b0;
          col_d = col_q + len;
          look_cnt_d = 2'd0;
          sq_d = lookup ? SqLook : SqRun;
        end
        if (do_finish) begin
          if (!packed_q) begin
            used = {rbc_d, 3'b000} - {11'd0, cnt_d};
            rbl_d = 13'({({1'b0, used[15:6]} + {10'd0, (used[5:0] != 6'd0)}), 3'b000});
          end
          buf_d = '0; cnt_d = '0; col_d = '0;
          if (row_q >= hm1_q) ph_d = PhDone;
          else begin
            row_d = row_q + 10'd1;
            if (rbc_q >= rbl_d) do_begin = 1'b1; else ph_d = PhSkip;
          end
        end
        // hand the staged run to the output, marked last when the transaction ends
        if (stage_v_q && (do_emit || sq_d == SqIdle)) begin
          if (ofree) begin
            ovalid_d = 1'b1;
            out_d = stage_q;
            out_d.last = !do_emit;
            if (!do_emit) stage_v_d = 1'b0;
          end else stall = 1'b1;
        end
        if (do_emit) stage_v_d = 1'b1;
      end
      SqLook: begin
        // palette read; the RAM registers the data, so it is valid in the cycle after the address
        look_cnt_d = look_cnt_q + 2'd1;
        if (look_cnt_q == 2'd1) begin
          stage_d.pixel_color = pal_rd | 16'h8000;
          sq_d = SqRun;
        end
      end
      default: sq_d = SqIdle;
    endcase

    if (do_begin) begin
      buf_d = '0; cnt_d = '0; rbc_d = '0; col_d = '0; pm_d = '0; prem_d = '0;
      ph_d = packed_q ? PhOffset : PhRaw;
    end

    // hold the step while the output register is still full
    if (stall) begin
      sq_d = sq_q; ph_d = ph_q; buf_d = buf_q; cnt_d = cnt_q; row_d = row_q; col_d = col_q;
      rbc_d = rbc_q; rbl_d = rbl_q; pm_d = pm_q; prem_d = prem_q;
      stage_v_d = stage_v_q; stage_d = stage_q; look_cnt_d = look_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q <= SqIdle; ph_q <= PhIdle; buf_q <= '0; cnt_q <= '0; row_q <= '0; col_q <= '0;
      rbc_q <= '0; rbl_q <= '0; pm_q <= '0; prem_q <= '0;
      ovalid_q <= 1'b0; stage_v_q <= 1'b0; look_cnt_q <= '0;
    end else begin
      sq_q <= sq_d; ph_q <= ph_d; buf_q <= buf_d; cnt_q <= cnt_d; row_q <= row_d;
      col_q <= col_d; rbc_q <= rbc_d; rbl_q <= rbl_d; pm_q <= pm_d; prem_q <= prem_d;
      ovalid_q <= ovalid_d; stage_v_q <= stage_v_d; look_cnt_q <= look_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    stage_q <= stage_d;
  end
endmodule

[verif/cel_image_decoder_core_tb.sv]
// Self-checking testbench for cel_image_decoder_core: random CEL images in, pixel runs checked.
// Depends on cid_pkg, cid_stream_if and the decoder RTL.
module cel_image_decoder_core_tb;
  import cid_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandItems = 240;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned CycleLimit = 1000000;

  typedef enum logic [2:0] {
    PhIdle, PhOffset, PhMode, PhCount, PhPixel, PhRaw, PhSkip, PhDone
  } dec_phase_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [10:0] cfg_data_i;

  cid_in_if  in_if ();
  cid_out_if out_if ();

  cel_image_decoder_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // Register shadow and decoder state mirrored by the run predictor
  logic [2:0]   reg_bpp;
  logic         reg_indexed;
  logic         reg_packed;
  logic [10:0]  reg_wm1;
  logic [9:0]   reg_hm1;
  logic [15:0]  pal_mem [PaletteEntries];
  int unsigned  bit_buf, bit_cnt, row_cnt, col_cnt, row_bytes, row_len, pkt_left;
  logic [1:0]   pkt_mode;
  dec_phase_e   phase;

  in_item_t    pending_items [$];
  out_item_t   expected_runs [$];
  bit          gen_bits [$];
  int unsigned send_idle_pct, recv_stall_pct;
  int unsigned rand_items;
  int unsigned error_cnt;
  int unsigned cycle_cnt;

  // Clock and cycle limit
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("cel_image_decoder_core_tb: done, errors");
      $finish;
    end
  end

  // ---------------- run predictor ----------------
  function automatic int unsigned pix_bits();
    case (reg_bpp)
      3'd0: return 1;
      3'd1: return 2;
      3'd2: return 4;
      3'd3: return 6;
      3'd4: return 8;
      default: return 16;
    endcase
  endfunction

  function automatic bit pix_indexed();
    int unsigned b;
    b = pix_bits();
    if (b < 8) return 1'b1;
    if (b >= 16) return 1'b0;
    return reg_indexed;
  endfunction

  function automatic int unsigned take_bits(int unsigned n);
    int unsigned v;
    v = (bit_buf >> (bit_cnt - n)) & ((1 << n) - 1);
    bit_cnt -= n;
    bit_buf &= (bit_cnt != 0) ? ((1 << bit_cnt) - 1) : 0;
    return v;
  endfunction

  function automatic void push_run(int unsigned color, int unsigned len);
    out_item_t   r;
    int unsigned w;
    w = reg_wm1 + 1;
    r.pixel_color = color[15:0];
    r.run_length  = len[11:0];
    r.row_number  = row_cnt[9:0];
    r.row_done    = (col_cnt + len) >= w;
    r.image_done  = r.row_done && (row_cnt >= reg_hm1);
    r.last        = 1'b0;
    col_cnt += len;
    expected_runs.push_back(r);
  endfunction

  function automatic void start_row();
    bit_buf   = 0;
    bit_cnt   = 0;
    row_bytes = 0;
    col_cnt   = 0;
    pkt_mode  = ModeEnd;
    pkt_left  = 0;
    phase     = reg_packed ? PhOffset : PhRaw;
  endfunction

  function automatic void close_row();
    int unsigned used;
    if (!reg_packed) begin
      used    = row_bytes * 8 - bit_cnt;
      row_len = ((used + 63) / 64) * 8;
    end
    bit_buf = 0;
    bit_cnt = 0;
    col_cnt = 0;
    if (row_cnt >= reg_hm1) begin
      phase = PhDone;
      return;
    end
    row_cnt = (row_cnt + 1) & 10'h3ff;
    if (row_bytes >= row_len) start_row();
    else phase = PhSkip;
  endfunction

  function automatic int unsigned pixel_color(int unsigned v, bit opaque);
    if (pix_indexed()) return (v < PaletteEntries ? pal_mem[v] : 16'h0) | 16'h8000;
    return opaque ? (v | 16'h8000) : v;
  endfunction

  // Consume buffered bits until the decoder needs more data
  function automatic void decode_bits();
    int unsigned pw, w, n, v, cnt, left;
    forever begin
      pw = pix_bits();
      w  = reg_wm1 + 1;
      case (phase)
        PhOffset: begin
          n = (pw >= 8) ? 16 : 8;
          if (bit_cnt < n) return;
          v = take_bits(n);
          if (n == 16) v &= 10'h3ff;
          row_len = (v + 2) * 4;
          phase = PhMode;
        end
        PhMode: begin
          if (col_cnt >= w) close_row();
          else if ((row_bytes * 8 - bit_cnt) / 8 >= row_len) begin
            push_run(0, w - col_cnt);
            close_row();
          end else begin
            if (bit_cnt < 2) return;
            pkt_mode = 2'(take_bits(2));
            if (pkt_mode == ModeEnd) begin
              push_run(0, w - col_cnt);
              close_row();
            end else phase = PhCount;
          end
        end
        PhCount: begin
          if (bit_cnt < 6) return;
          cnt  = take_bits(6) + 1;
          left = (col_cnt < w) ? (w - col_cnt) : 0;
          if (cnt > left) cnt = left;
          if (cnt == 0) close_row();
          else if (pkt_mode == ModeTrans) begin
            push_run(0, cnt);
            if (col_cnt >= w) close_row();
            else phase = PhMode;
          end else begin
            pkt_left = cnt;
            phase = PhPixel;
          end
        end
        PhPixel: begin
          if (bit_cnt < pw) return;
          v = pixel_color(take_bits(pw), 1'b1);
          if (pkt_mode == ModeRep) begin
            push_run(v, pkt_left);
            pkt_left = 0;
          end else begin
            push_run(v, 1);
            pkt_left--;
          end
          if (col_cnt >= w) close_row();
          else if (pkt_left == 0) phase = PhMode;
        end
        PhRaw: begin
          if (col_cnt >= w) close_row();
          else begin
            if (bit_cnt < pw) return;
            push_run(pixel_color(take_bits(pw), 1'b0), 1);
            if (col_cnt >= w) close_row();
          end
        end
        default: return;
      endcase
    end
  endfunction

  function automatic void predict_runs(in_item_t it);
    int unsigned n0;
    n0 = expected_runs.size();
    case (it.kind)
      KindPal: pal_mem[it.table_index] = it.table_value;
      KindStart: begin
        row_cnt = 0;
        row_len = 0;
        start_row();
      end
      KindData: begin
        if (phase == PhSkip) begin
          if (row_bytes < 8191) row_bytes++;
          if (row_bytes >= row_len) start_row();
        end else if (phase != PhIdle && phase != PhDone) begin
          bit_buf = ((bit_buf << 8) | it.data_byte) & 24'hffffff;
          bit_cnt += 8;
          if (row_bytes < 8191) row_bytes++;
          decode_bits();
        end
      end
      default: ;
    endcase
    if (expected_runs.size() > n0) expected_runs[expected_runs.size() - 1].last = 1'b1;
  endfunction

  // ---------------- driver and monitor ----------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else begin
      if (in_if.valid && in_if.ready) predict_runs(in_if.data);
      if (!in_if.valid || in_if.ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.data  <= pending_items.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want, got;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= $urandom_range(99) >= recv_stall_pct;
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (expected_runs.size() == 0) begin
          $display("%0t: unexpected run, expected none, actual %h", $realtime, got);
          error_cnt++;
        end else begin
          want = expected_runs.pop_front();
          if (got.pixel_color !== want.pixel_color) begin
            $display("%0t: pixel_color expected %h actual %h", $realtime,
                     want.pixel_color, got.pixel_color);
            error_cnt++;
          end
          if (got.run_length !== want.run_length) begin
            $display("%0t: run_length expected %0d actual %0d", $realtime,
                     want.run_length, got.run_length);
            error_cnt++;
          end
          if (got.row_number !== want.row_number) begin
            $display("%0t: row_number expected %0d actual %0d", $realtime,
                     want.row_number, got.row_number);
            error_cnt++;
          end
          if (got.row_done !== want.row_done) begin
            $display("%0t: row_done expected %b actual %b", $realtime,
                     want.row_done, got.row_done);
            error_cnt++;
          end
          if (got.image_done !== want.image_done) begin
            $display("%0t: image_done expected %b actual %b", $realtime,
                     want.image_done, got.image_done);
            error_cnt++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last expected %b actual %b", $realtime, want.last, got.last);
            error_cnt++;
          end
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic add_item(logic [1:0] kind, logic [7:0] idx, logic [15:0] val,
                          logic [7:0] dat);
    in_item_t it;
    it.kind        = kind;
    it.table_index = idx;
    it.table_value = val;
    it.data_byte   = dat;
    pending_items.push_back(it);
    rand_items++;
  endtask

  task automatic put_bits(int unsigned v, int unsigned n);
    for (int i = n - 1; i >= 0; i--) gen_bits.push_back(v[i]);
  endtask

  // Pixel value: palette indices stay within the loaded entries
  function automatic int unsigned pix_value();
    if (pix_indexed()) return $urandom_range(0, 63);
    return $urandom;
  endfunction

  // Emit exactly nbytes data bytes: drop surplus bits, pad with random ones
  task automatic flush_bytes(int unsigned nbytes);
    logic [7:0] b;
    for (int unsigned i = 0; i < nbytes; i++) begin
      for (int k = 7; k >= 0; k--)
        b[k] = (gen_bits.size() > 0) ? gen_bits.pop_front() : $urandom_range(1);
      add_item(KindData, 8'($urandom), 16'($urandom), b);
    end
    gen_bits.delete();
  endtask

  task automatic gen_row_packed();
    int unsigned pw, w, cols, mode, cnt, n_off, nbytes, words, off, max_off, r;
    logic [15:0] off_word;
    pw = pix_bits();
    w = reg_wm1 + 1;
    n_off = (pw >= 8) ? 16 : 8;
    max_off = (pw >= 8) ? 1023 : 255;
    cols = 0;
    while (cols < w) begin
      if ($urandom_range(15) == 0) begin
        put_bits(ModeEnd, 2);
        break;
      end
      mode = $urandom_range(1, 3);
      cnt = (mode == ModeLit) ? $urandom_range(0, 7) : $urandom_range(0, 63);
      put_bits(mode, 2);
      put_bits(cnt, 6);
      if (mode == ModeLit) begin
        for (int unsigned k = 0; k <= cnt; k++) put_bits(pix_value(), pw);
      end else if (mode == ModeRep) begin
        put_bits(pix_value(), pw);
      end
      cols += cnt + 1;
    end
    nbytes = (gen_bits.size() + n_off + 7) / 8;
    words = (nbytes + 3) / 4;
    off = (words > 2) ? words - 2 : 0;
    r = $urandom_range(11);
    // Short rows at 8bpp indexed would read stray bytes as palette indices
    if (r == 0 && !(pw == 8 && pix_indexed())) off = $urandom_range(0, off);
    else if (r > 0 && r < 4) off += $urandom_range(1, 2);
    if (off > max_off) off = max_off;
    off_word = (n_off == 16) ? {6'($urandom), off[9:0]} : {8'h0, off[7:0]};
    for (int unsigned i = 0; i < n_off; i++) gen_bits.push_front(off_word[i]);
    flush_bytes((off + 2) * 4);
  endtask

  task automatic gen_row_raw();
    int unsigned pw, w;
    pw = pix_bits();
    w = reg_wm1 + 1;
    for (int unsigned i = 0; i < w; i++) put_bits(pix_value(), pw);
    flush_bytes(((w * pw + 63) / 64) * 8);
  endtask

  task automatic gen_image(int unsigned rows);
    add_item(KindStart, 8'($urandom), 16'($urandom), 8'($urandom));
    for (int unsigned i = 0; i < rows; i++) begin
      if (reg_packed) gen_row_packed();
      else gen_row_raw();
    end
  endtask

  // Hold until the block is drained, then let any silent work finish
  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_items.size() > 0 || in_if.valid || expected_runs.size() > 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [2:0] bpp, logic ind, logic pk, logic [10:0] wm1,
                            logic [9:0] hm1);
    logic [10:0] vals [5];
    logic [2:0]  idx  [5];
    vals = '{11'(bpp), 11'(ind), 11'(pk), wm1, 11'(hm1)};
    idx  = '{CfgBpp, CfgIndex, CfgPacked, CfgWidth, CfgHeight};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    reg_bpp = bpp;
    reg_indexed = ind;
    reg_packed = pk;
    reg_wm1 = wm1;
    reg_hm1 = hm1;
  endtask

  task automatic run_image(logic [2:0] bpp, logic ind, logic pk, logic [10:0] wm1,
                           logic [9:0] hm1, int unsigned rows);
    write_regs(bpp, ind, pk, wm1, hm1);
    gen_image(rows);
    wait_drained();
  endtask

  initial begin
    logic [2:0]  bpp;
    logic [10:0] wm1;
    logic [9:0]  hm1;
    cycle_cnt = 0;
    error_cnt = 0;
    rand_items = 0;
    send_idle_pct = 8;
    recv_stall_pct = 81;
    cfg_we_i = 1'b0;
    cfg_index_i = CfgBpp;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    reg_bpp = 3'd4;
    reg_indexed = 1'b1;
    reg_packed = 1'b1;
    reg_wm1 = '0;
    reg_hm1 = '0;
    bit_buf = 0;
    bit_cnt = 0;
    row_cnt = 0;
    col_cnt = 0;
    row_bytes = 0;
    row_len = 0;
    pkt_left = 0;
    pkt_mode = ModeEnd;
    phase = PhIdle;
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Load every palette entry that the stimulus can read
    add_item(KindPal, 8'd0, 16'h0000, 8'h00);
    for (int i = 1; i < 64; i++) add_item(KindPal, 8'(i), 16'($urandom), 8'($urandom));
    add_item(KindPal, 8'd255, 16'hffff, 8'hff);
    // Data before any start and an unknown kind are both dropped
    add_item(KindData, 8'h00, 16'h0000, 8'hff);
    add_item(2'd3, 8'hff, 16'hffff, 8'h00);
    // Reset configuration: 8bpp indexed packed 1x1, all-zero then all-ones bytes
    add_item(KindStart, 8'h00, 16'h0000, 8'h00);
    add_item(KindData, 8'h00, 16'h0000, 8'h00);
    add_item(KindData, 8'h00, 16'h0000, 8'h00);
    add_item(KindData, 8'h00, 16'h0000, 8'hff);
    add_item(KindData, 8'h00, 16'h0000, 8'hff);
    wait_drained();

    // Directed settings: depth extremes, raw mode, unused depth code, direct colour
    run_image(3'd0, 1'b1, 1'b0, 11'd0, 10'd0, 1);
    run_image(3'd5, 1'b0, 1'b1, 11'd3, 10'd1, 2);
    run_image(3'd6, 1'b0, 1'b1, 11'd2, 10'd0, 1);
    run_image(3'd4, 1'b0, 1'b1, 11'd4, 10'd0, 1);
    run_image(3'd2, 1'b1, 1'b1, 11'd5, 10'd1023, 3);
    run_image(3'd0, 1'b1, 1'b0, 11'd255, 10'd0, 1);
    // Bytes past the last row are ignored
    add_item(KindData, 8'($urandom), 16'($urandom), 8'($urandom));
    wait_drained();

    // Random images under three idle regimes
    rand_items = 0;
    while (rand_items < RandItems) begin
      if (rand_items < RandItems / 3) begin
        send_idle_pct = 8;
        recv_stall_pct = 81;
      end else if (rand_items < 2 * RandItems / 3) begin
        send_idle_pct = 81;
        recv_stall_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      bpp = $urandom_range(0, 5);
      wm1 = ($urandom_range(9) == 0) ? $urandom_range(16, 300) : $urandom_range(0, 15);
      hm1 = $urandom_range(0, 3);
      write_regs(bpp, $urandom_range(1), $urandom_range(3) != 0, wm1, hm1);
      if ($urandom_range(7) == 0)
        add_item(KindPal, 8'($urandom), 16'($urandom), 8'($urandom));
      if ($urandom_range(9) == 0) add_item(2'd3, 8'($urandom), 16'($urandom), 8'($urandom));
      // Sometimes abandon an image partway and restart
      if ($urandom_range(7) == 0) gen_image($urandom_range(0, hm1));
      gen_image(hm1 + 1);
      if ($urandom_range(5) == 0)
        add_item(KindData, 8'($urandom), 16'($urandom), 8'($urandom));
      wait_drained();
    end

    if (error_cnt == 0) begin
      $display("cel_image_decoder_core_tb: done, clean");
    end else begin
      $display("cel_image_decoder_core_tb: done, errors");
    end
    $finish;
  end
endmodule
